[src/softmax_top1_class_tally_core_defines.svh]
// assertion macros for the softmax top-1 classifier checker
// no dependencies; included by the checker file
`ifndef SOFTMAX_TOP1_CLASS_TALLY_CORE_DEFINES_SVH
`define SOFTMAX_TOP1_CLASS_TALLY_CORE_DEFINES_SVH

// same-cycle implication, reset disables
`define SMX_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smx assertion failed");

// next-cycle implication, reset disables
`define SMX_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smx assertion failed");

`endif

[src/smx_pkg.sv]
// shared widths, constants, exp table and struct types for the classifier
// no dependencies
package smx_pkg;

    localparam int LOGIT_INPUTS    = 5;
    localparam int NUM_CLASSES_DEF = 5;
    localparam int LOGIT_W         = 16;
    localparam int CNT_W           = 3;
    localparam int CLASS_W         = 3;
    localparam int CONF_W          = 14;
    localparam int HITS_W          = 32;
    localparam int CSUM_W          = 48;
    localparam int EXP_W           = 17;
    localparam int SUM_W           = 19;
    localparam int REM_W           = SUM_W + 1;
    localparam int FRAC_W          = 8;
    localparam int SHIFT_W         = 9;
    localparam int PROD_W          = 33;
    localparam int DIV_STEPS       = CONF_W;
    localparam int NUM_W           = EXP_W + CONF_W;

    localparam logic [EXP_W-1:0]   LOG2E_Q16     = 17'd94548;
    localparam logic [EXP_W-1:0]   ONE_Q16       = 17'd65536;
    localparam logic [CONF_W-1:0]  CONF_SCALE    = 14'd10000;
    localparam logic [SHIFT_W-1:0] EXP_MAX_SHIFT = 9'd16;
    localparam logic [HITS_W-1:0]  HITS_MAX      = '1;
    localparam logic [CSUM_W-1:0]  CSUM_MAX      = '1;

    // 2^-(2^-(k+1)) in q16
    function automatic logic [15:0] exp_frac(input logic [2:0] k);
        logic [15:0] c;
        case (k)
            3'd0:    c = 16'd46341;
            3'd1:    c = 16'd55109;
            3'd2:    c = 16'd60097;
            3'd3:    c = 16'd62757;
            3'd4:    c = 16'd64132;
            3'd5:    c = 16'd64830;
            3'd6:    c = 16'd65182;
            default: c = 16'd65359;
        endcase
        return c;
    endfunction

    typedef struct packed {
        logic [CLASS_W-1:0] best;
        logic [CONF_W-1:0]  conf;
    } smx_pred_t;

    typedef struct packed {
        logic [CLASS_W-1:0] best_class;
        logic [CONF_W-1:0]  confidence;
        logic [HITS_W-1:0]  class_hits;
        logic [CSUM_W-1:0]  class_conf_total;
        logic [HITS_W-1:0]  total_hits;
        logic [CLASS_W-1:0] leading_class;
    } smx_result_t;

endpackage

[src/smx_ifs.sv]
// request channels of the classifier: logits in, prediction out
// depends on smx_pkg
interface smx_sample_if;
    import smx_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [LOGIT_W-1:0] logit_a;
    logic signed [LOGIT_W-1:0] logit_b;
    logic signed [LOGIT_W-1:0] logit_c;
    logic signed [LOGIT_W-1:0] logit_d;
    logic signed [LOGIT_W-1:0] logit_e;
    logic [CNT_W-1:0]          num_valid;
    modport source (output valid, logit_a, logit_b, logit_c, logit_d, logit_e, num_valid,
                    input ready);
    modport sink (input valid, logit_a, logit_b, logit_c, logit_d, logit_e, num_valid,
                  output ready);
endinterface

interface smx_result_if;
    import smx_pkg::*;
    logic               valid;
    logic               ready;
    logic [CLASS_W-1:0] best_class;
    logic [CONF_W-1:0]  confidence;
    logic [HITS_W-1:0]  class_hits;
    logic [CSUM_W-1:0]  class_conf_total;
    logic [HITS_W-1:0]  total_hits;
    logic [CLASS_W-1:0] leading_class;
    modport source (output valid, best_class, confidence, class_hits, class_conf_total,
                    total_hits, leading_class, input ready);
    modport sink (input valid, best_class, confidence, class_hits, class_conf_total,
                  total_hits, leading_class, output ready);
endinterface

[src/smx_lane.sv]
// one exp lane: exp(-d/256) in q16, one fraction bit per cycle
// depends on smx_pkg
module smx_lane (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [smx_pkg::LOGIT_W-1:0]  diff,
    output logic [smx_pkg::EXP_W-1:0]    e,
    output logic                         done
);
    import smx_pkg::*;

    typedef enum logic [1:0] {L_IDLE, L_ITER, L_SHIFT} lane_state_t;

    lane_state_t        state_reg, state_next;
    logic [2:0]         k_reg, k_next;
    logic [SHIFT_W-1:0] n_reg, n_next;
    logic [FRAC_W-1:0]  f_reg, f_next;
    logic [EXP_W-1:0]   v_reg, v_next;
    logic [EXP_W-1:0]   e_reg, e_next;
    logic               done_reg, done_next;
    logic [PROD_W-1:0]  t_full;
    logic [PROD_W-1:0]  mul;

    assign t_full = PROD_W'(diff) * PROD_W'(LOG2E_Q16);
    assign mul    = PROD_W'(v_reg) * PROD_W'(exp_frac(k_reg));

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        f_next     = f_reg;
        v_next     = v_reg;
        e_next     = e_reg;
        done_next  = 1'b0;
        case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    n_next     = t_full[PROD_W-1:24];
                    f_next     = t_full[23:16];
                    v_next     = ONE_Q16;
                    k_next     = '0;
                    state_next = L_ITER;
                end
            end
            L_ITER:
            begin
                if (f_reg[FRAC_W-1])
                begin
                    v_next = mul[PROD_W-1:16];
                end
                f_next = f_reg << 1;
                k_next = k_reg + 3'd1;
                if (k_reg == 3'(FRAC_W - 1))
                begin
                    state_next = L_SHIFT;
                end
            end
            L_SHIFT:
            begin
                e_next     = (n_reg > EXP_MAX_SHIFT) ? '0 : (v_reg >> n_reg[4:0]);
                done_next  = 1'b1;
                state_next = L_IDLE;
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            k_reg     <= '0;
            n_reg     <= '0;
            f_reg     <= '0;
            v_reg     <= '0;
            e_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
            f_reg     <= f_next;
            v_reg     <= v_next;
            e_reg     <= e_next;
            done_reg  <= done_next;
        end
    end

    assign e    = e_reg;
    assign done = done_reg;

endmodule

[src/smx_merge.sv]
// merge of lane results: exp sum, top class, and confidence by serial division
// depends on smx_pkg
module smx_merge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [smx_pkg::EXP_W-1:0]   e [smx_pkg::LOGIT_INPUTS],
    input  logic [smx_pkg::CNT_W-1:0]   count,
    output logic                        done,
    output smx_pkg::smx_pred_t          pred
);
    import smx_pkg::*;

    typedef enum logic [1:0] {M_IDLE, M_SCALE, M_DIV} merge_state_t;

    localparam int STEP_W = $clog2(DIV_STEPS);

    merge_state_t       state_reg, state_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CLASS_W-1:0] best_reg, best_next;
    logic [EXP_W-1:0]   ebest_reg, ebest_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [CONF_W-1:0]  low_reg, low_next;
    logic [CONF_W-1:0]  q_reg, q_next;
    logic [CONF_W-1:0]  conf_reg, conf_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               done_reg, done_next;
    logic [SUM_W-1:0]   sum_c;
    logic [CLASS_W-1:0] best_c;
    logic [NUM_W-1:0]   num;
    logic [REM_W-1:0]   trial;

    always_comb
    begin
        sum_c  = '0;
        best_c = '0;
        for (int i = 0; i < LOGIT_INPUTS; i++)
        begin
            if (CNT_W'(i) < count)
            begin
                sum_c = sum_c + SUM_W'(e[i]);
                if (e[i] > e[best_c])
                begin
                    best_c = CLASS_W'(i);
                end
            end
        end
    end

    assign num   = NUM_W'(ebest_reg) * NUM_W'(CONF_SCALE);
    assign trial = {rem_reg[REM_W-2:0], low_reg[CONF_W-1]};

    always_comb
    begin
        state_next = state_reg;
        sum_next   = sum_reg;
        best_next  = best_reg;
        ebest_next = ebest_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        q_next     = q_reg;
        conf_next  = conf_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    sum_next   = sum_c;
                    best_next  = best_c;
                    ebest_next = e[best_c];
                    state_next = M_SCALE;
                end
            end
            M_SCALE:
            begin
                rem_next   = REM_W'(num[NUM_W-1:CONF_W]);
                low_next   = num[CONF_W-1:0];
                q_next     = '0;
                step_next  = '0;
                state_next = M_DIV;
            end
            M_DIV:
            begin
                if (trial >= REM_W'(sum_reg))
                begin
                    rem_next = trial - REM_W'(sum_reg);
                    q_next   = {q_reg[CONF_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    q_next   = {q_reg[CONF_W-2:0], 1'b0};
                end
                low_next  = low_reg << 1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    conf_next  = q_next;
                    done_next  = 1'b1;
                    state_next = M_IDLE;
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            sum_reg   <= '0;
            best_reg  <= '0;
            ebest_reg <= '0;
            rem_reg   <= '0;
            low_reg   <= '0;
            q_reg     <= '0;
            conf_reg  <= '0;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            best_reg  <= best_next;
            ebest_reg <= ebest_next;
            rem_reg   <= rem_next;
            low_reg   <= low_next;
            q_reg     <= q_next;
            conf_reg  <= conf_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    assign done      = done_reg;
    assign pred.best = best_reg;
    assign pred.conf = conf_reg;

endmodule

[src/smx_tally.sv]
// per-class hit and confidence tallies, running total, majority scan
// depends on smx_pkg
module smx_tally #(
    parameter int NUM_CLASSES = smx_pkg::NUM_CLASSES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  smx_pkg::smx_pred_t   pred,
    input  logic                 out_free,
    output logic                 done,
    output smx_pkg::smx_result_t res
);
    import smx_pkg::*;

    typedef enum logic [1:0] {T_IDLE, T_UPD, T_SCAN, T_HOLD} tally_state_t;

    localparam int IW = $clog2(NUM_CLASSES);

    tally_state_t      state_reg, state_next;
    logic [HITS_W-1:0] hits_reg [NUM_CLASSES];
    logic [HITS_W-1:0] hits_next [NUM_CLASSES];
    logic [CSUM_W-1:0] csum_reg [NUM_CLASSES];
    logic [CSUM_W-1:0] csum_next [NUM_CLASSES];
    logic [HITS_W-1:0] total_reg, total_next;
    smx_pred_t         pred_reg, pred_next;
    logic [IW-1:0]     scan_reg, scan_next;
    logic [HITS_W-1:0] maxv_reg, maxv_next;
    logic [IW-1:0]     major_reg, major_next;
    logic [HITS_W-1:0] hout_reg, hout_next;
    logic [CSUM_W-1:0] cout_reg, cout_next;
    logic              done_reg, done_next;
    logic [IW-1:0]     rd_idx;
    logic [HITS_W-1:0] rd_hits;
    logic [CSUM_W-1:0] rd_csum;
    logic [CSUM_W:0]   csum_add;
    logic [HITS_W-1:0] hits_inc;
    logic [CSUM_W-1:0] csum_sat;

    assign rd_idx   = (state_reg == T_UPD) ? IW'(pred_reg.best) : scan_reg;
    assign rd_hits  = hits_reg[rd_idx];
    assign rd_csum  = csum_reg[rd_idx];
    assign csum_add = (CSUM_W + 1)'(rd_csum) + (CSUM_W + 1)'(pred_reg.conf);
    assign csum_sat = csum_add[CSUM_W] ? CSUM_MAX : csum_add[CSUM_W-1:0];
    assign hits_inc = (rd_hits == HITS_MAX) ? rd_hits : rd_hits + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        hits_next  = hits_reg;
        csum_next  = csum_reg;
        total_next = total_reg;
        pred_next  = pred_reg;
        scan_next  = scan_reg;
        maxv_next  = maxv_reg;
        major_next = major_reg;
        hout_next  = hout_reg;
        cout_next  = cout_reg;
        done_next  = 1'b0;
        case (state_reg)
            T_IDLE:
            begin
                if (start)
                begin
                    pred_next  = pred;
                    state_next = T_UPD;
                end
            end
            T_UPD:
            begin
                hits_next[rd_idx] = hits_inc;
                csum_next[rd_idx] = csum_sat;
                hout_next         = hits_inc;
                cout_next         = csum_sat;
                total_next        = (total_reg == HITS_MAX) ? total_reg : total_reg + 1'b1;
                scan_next         = '0;
                state_next        = T_SCAN;
            end
            T_SCAN:
            begin
                if (scan_reg == '0 || rd_hits > maxv_reg)
                begin
                    maxv_next  = rd_hits;
                    major_next = scan_reg;
                end
                if (scan_reg == IW'(NUM_CLASSES - 1))
                begin
                    state_next = T_HOLD;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            T_HOLD:
            begin
                if (out_free)
                begin
                    done_next  = 1'b1;
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                hits_reg[i] <= '0;
                csum_reg[i] <= '0;
            end
            total_reg <= '0;
            pred_reg  <= '0;
            scan_reg  <= '0;
            maxv_reg  <= '0;
            major_reg <= '0;
            hout_reg  <= '0;
            cout_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hits_reg  <= hits_next;
            csum_reg  <= csum_next;
            total_reg <= total_next;
            pred_reg  <= pred_next;
            scan_reg  <= scan_next;
            maxv_reg  <= maxv_next;
            major_reg <= major_next;
            hout_reg  <= hout_next;
            cout_reg  <= cout_next;
            done_reg  <= done_next;
        end
    end

    assign done                 = done_reg;
    assign res.best_class       = pred_reg.best;
    assign res.confidence       = pred_reg.conf;
    assign res.class_hits       = hout_reg;
    assign res.class_conf_total = cout_reg;
    assign res.total_hits       = total_reg;
    assign res.leading_class    = CLASS_W'(major_reg);

endmodule

[src/softmax_top1_class_tally_core.sv]
// top level of the softmax top-1 classifier with per-class tallies
// depends on smx_pkg, smx_ifs, smx_lane, smx_merge, smx_tally
//
// channel  dir  contents
// sample   in   logit_a..logit_e (signed q8.8), num_valid
// result   out  best_class, confidence, class_hits, class_conf_total,
//               total_hits, leading_class
//
// one request at a time; from accept to result it runs through five exp lanes, a
// fourteen-step divider, then a majority scan that reads one class counter per cycle.
// a request with a zero count is taken and dropped without a result.
// reset clears all tallies at once; the result register holds under stall
// and a new request is taken while it waits.
module softmax_top1_class_tally_core #(
    parameter int NUM_CLASSES = smx_pkg::NUM_CLASSES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    smx_sample_if.sink    sample,
    smx_result_if.source  result
);
    import smx_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_MAX, S_START, S_WAIT} top_state_t;

    localparam logic [CNT_W-1:0] CNT_LIMIT =
        CNT_W'((NUM_CLASSES < LOGIT_INPUTS) ? NUM_CLASSES : LOGIT_INPUTS);

    top_state_t                state_reg, state_next;
    logic signed [LOGIT_W-1:0] logit_reg [LOGIT_INPUTS];
    logic signed [LOGIT_W-1:0] logit_next [LOGIT_INPUTS];
    logic [LOGIT_W-1:0]        diff_reg [LOGIT_INPUTS];
    logic [LOGIT_W-1:0]        diff_next [LOGIT_INPUTS];
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      out_valid_reg, out_valid_next;
    smx_result_t               result_reg, result_next;
    logic [CNT_W-1:0]          cnt_in;
    logic                      accept;
    logic signed [LOGIT_W-1:0] mx;
    logic [LOGIT_W:0]          dwide [LOGIT_INPUTS];
    logic                      lane_start;
    logic [LOGIT_INPUTS-1:0]   lane_done;
    logic [EXP_W-1:0]          lane_e [LOGIT_INPUTS];
    logic                      merge_done;
    smx_pred_t                 pred;
    logic                      tally_done;
    smx_result_t               tally_res;
    logic                      out_free;

    assign sample.ready = (state_reg == S_IDLE);
    assign accept       = sample.valid && sample.ready;
    assign cnt_in       = (sample.num_valid > CNT_LIMIT) ? CNT_LIMIT : sample.num_valid;
    assign lane_start   = (state_reg == S_START);
    assign out_free     = !out_valid_reg || result.ready;

    always_comb
    begin
        mx = logit_reg[0];
        for (int i = 1; i < LOGIT_INPUTS; i++)
        begin
            if (CNT_W'(i) < count_reg && logit_reg[i] > mx)
            begin
                mx = logit_reg[i];
            end
        end
        for (int i = 0; i < LOGIT_INPUTS; i++)
        begin
            dwide[i] = {mx[LOGIT_W-1], mx} - {logit_reg[i][LOGIT_W-1], logit_reg[i]};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        logit_next = logit_reg;
        diff_next  = diff_reg;
        count_next = count_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && cnt_in != '0)
                begin
                    logit_next[0] = sample.logit_a;
                    logit_next[1] = sample.logit_b;
                    logit_next[2] = sample.logit_c;
                    logit_next[3] = sample.logit_d;
                    logit_next[4] = sample.logit_e;
                    count_next    = cnt_in;
                    state_next    = S_MAX;
                end
            end
            S_MAX:
            begin
                for (int i = 0; i < LOGIT_INPUTS; i++)
                begin
                    diff_next[i] = dwide[i][LOGIT_W-1:0];
                end
                state_next = S_START;
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (tally_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        if (tally_done)
        begin
            out_valid_next = 1'b1;
            result_next    = tally_res;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            for (int i = 0; i < LOGIT_INPUTS; i++)
            begin
                logit_reg[i] <= '0;
                diff_reg[i]  <= '0;
            end
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            logit_reg     <= logit_next;
            diff_reg      <= diff_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            result_reg    <= result_next;
        end
    end

    for (genvar g = 0; g < LOGIT_INPUTS; g++)
    begin : g_lane
        smx_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .start (lane_start),
            .diff  (diff_reg[g]),
            .e     (lane_e[g]),
            .done  (lane_done[g])
        );
    end

    smx_merge u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .start (&lane_done),
        .e     (lane_e),
        .count (count_reg),
        .done  (merge_done),
        .pred  (pred)
    );

    smx_tally #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_tally (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (merge_done),
        .pred     (pred),
        .out_free (out_free),
        .done     (tally_done),
        .res      (tally_res)
    );

    assign result.valid            = out_valid_reg;
    assign result.best_class       = result_reg.best_class;
    assign result.confidence       = result_reg.confidence;
    assign result.class_hits       = result_reg.class_hits;
    assign result.class_conf_total = result_reg.class_conf_total;
    assign result.total_hits       = result_reg.total_hits;
    assign result.leading_class    = result_reg.leading_class;

endmodule

[src/smx_checker.sv]
// port-level checks on the classifier, bound to the top level
// depends on smx_pkg and softmax_top1_class_tally_core_defines.svh
`include "softmax_top1_class_tally_core_defines.svh"

module smx_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [smx_pkg::CLASS_W-1:0]   best_class,
    input logic [smx_pkg::CONF_W-1:0]    confidence,
    input logic [smx_pkg::HITS_W-1:0]    total_hits,
    input logic [smx_pkg::HITS_W-1:0]    class_hits
);
    import smx_pkg::*;

    // stalled result holds
    `SMX_ASSERT_NXT(a_hold, result_valid && !result_ready, result_valid && $stable(confidence) && $stable(best_class))
    // winner of at most five classes has at least a fifth
    `SMX_ASSERT_IMP(a_conf_range, result_valid, confidence >= 14'd2000 && confidence <= 14'd10000)
    `SMX_ASSERT_IMP(a_best_range, result_valid, best_class <= 3'd4)
    // a class count never exceeds the running total
    `SMX_ASSERT_IMP(a_hits_total, result_valid, class_hits != '0 && class_hits <= total_hits)

endmodule

bind softmax_top1_class_tally_core smx_checker u_smx_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .best_class   (result.best_class),
    .confidence   (result.confidence),
    .total_hits   (result.total_hits),
    .class_hits   (result.class_hits)
);

[test/softmax_top1_class_tally_core_tb.sv]
// testbench for the softmax top-1 classifier with per-class tallies
// drives logit requests, predicts each result from its own tally copy and checks it
// depends on smx_pkg, smx_ifs and the rtl of softmax_top1_class_tally_core
`timescale 1ns / 100ps

module softmax_top1_class_tally_core_tb;
    import smx_pkg::*;

    localparam int NCLS = 5;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    int   errors;
    int   idle_cycles;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_off;
    logic [HITS_W-1:0] tally_hits [NCLS];
    logic [CSUM_W-1:0] tally_conf [NCLS];
    logic [HITS_W-1:0] tally_total;
    smx_result_t expected_q [$];

    smx_sample_if sample ();
    smx_result_if result ();

    softmax_top1_class_tally_core #(.NUM_CLASSES(NCLS)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample.sink),
        .result (result.source)
    );

    always #10 clk = ~clk;

    function automatic logic [EXP_W-1:0] exp_of_gap(input logic [15:0] gap);
        logic [63:0] t;
        logic [63:0] v;
        logic [7:0]  f;
        logic [63:0] n;
        t = 64'(gap) * 64'(94548);
        n = t >> 24;
        f = t[23:16];
        v = 64'd65536;
        if (f[7]) v = (v * 64'd46341) >> 16;
        if (f[6]) v = (v * 64'd55109) >> 16;
        if (f[5]) v = (v * 64'd60097) >> 16;
        if (f[4]) v = (v * 64'd62757) >> 16;
        if (f[3]) v = (v * 64'd64132) >> 16;
        if (f[2]) v = (v * 64'd64830) >> 16;
        if (f[1]) v = (v * 64'd65182) >> 16;
        if (f[0]) v = (v * 64'd65359) >> 16;
        if (n > 16)
            return '0;
        return EXP_W'(v >> n);
    endfunction

    task automatic predict_classification(input logic signed [15:0] lg [5],
                                          input logic [2:0] cnt_in);
        int cnt;
        int mx;
        int best;
        int major;
        logic [EXP_W-1:0] e [5];
        logic [63:0] sum;
        logic [63:0] conf;
        logic [63:0] csum;
        smx_result_t r;
        cnt = cnt_in > NCLS ? NCLS : cnt_in;
        if (cnt == 0)
            return;
        mx = lg[0];
        for (int i = 1; i < cnt; i++)
            if (int'(lg[i]) > mx)
                mx = lg[i];
        sum = 0;
        best = 0;
        for (int i = 0; i < cnt; i++)
        begin
            e[i] = exp_of_gap(16'(mx - int'(lg[i])));
            sum += e[i];
            if (e[i] > e[best])
                best = i;
        end
        conf = (64'(e[best]) * 64'd10000) / sum;
        if (tally_hits[best] != HITS_MAX)
            tally_hits[best]++;
        csum = 64'(tally_conf[best]) + conf;
        tally_conf[best] = csum > 64'(CSUM_MAX) ? CSUM_MAX : csum[CSUM_W-1:0];
        if (tally_total != HITS_MAX)
            tally_total++;
        major = 0;
        for (int i = 1; i < NCLS; i++)
            if (tally_hits[i] > tally_hits[major])
                major = i;
        r.best_class = CLASS_W'(best);
        r.confidence = CONF_W'(conf);
        r.class_hits = tally_hits[best];
        r.class_conf_total = tally_conf[best];
        r.total_hits = tally_total;
        r.leading_class = CLASS_W'(major);
        expected_q.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // one request, held until accepted
    task automatic send_logits(input logic signed [15:0] lg [5], input logic [2:0] cnt);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            sample.valid <= 1'b0;
            @(posedge clk);
        end
        sample.valid     <= 1'b1;
        sample.logit_a   <= lg[0];
        sample.logit_b   <= lg[1];
        sample.logit_c   <= lg[2];
        sample.logit_d   <= lg[3];
        sample.logit_e   <= lg[4];
        sample.num_valid <= cnt;
        @(posedge clk);
        while (!sample.ready)
            @(posedge clk);
        predict_classification(lg, cnt);
    endtask

    task automatic send_random(input int items, input bit near);
        logic signed [15:0] lg [5];
        int base;
        for (int n = 0; n < items; n++)
        begin
            base = $urandom_range(65535, 0) - 32768;
            for (int i = 0; i < 5; i++)
                if (near && $urandom_range(3, 0) != 0)
                    lg[i] = 16'(base + int'($urandom_range(2047, 0)) - 1024);
                else
                    lg[i] = 16'($urandom);
            if ($urandom_range(9, 0) == 0)
                lg[$urandom_range(4, 0)] = 16'(base);
            send_logits(lg, 3'($urandom_range(7, 0)));
        end
    endtask

    task automatic wait_drained();
        sample.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic test_directed();
        logic signed [15:0] lg [5];
        lg = '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
        send_logits(lg, 3'd5);
        lg = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001};
        send_logits(lg, 3'd5);
        lg = '{16'sh0100, 16'sh0100, 16'sh0100, 16'sh0100, 16'sh0100};
        send_logits(lg, 3'd5);
        send_logits(lg, 3'd0);
        send_logits(lg, 3'd7);
        send_logits(lg, 3'd6);
        send_logits(lg, 3'd1);
        lg = '{16'sh0000, 16'sh0200, 16'sh0200, 16'sh0000, 16'sh0000};
        send_logits(lg, 3'd3);
        send_logits(lg, 3'd2);
        lg = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0800};
        send_logits(lg, 3'd5);
        send_logits(lg, 3'd4);
        lg = '{16'sh0000, 16'sh0001, 16'sh0b17, 16'sh1100, 16'sh10ff};
        send_logits(lg, 3'd5);
        lg = '{16'shaaaa, 16'sh5555, 16'sh0f0f, 16'shf0f0, 16'sh3333};
        send_logits(lg, 3'd5);
        lg = '{16'sh5555, 16'shaaaa, 16'shf0f0, 16'sh0f0f, 16'shcccc};
        send_logits(lg, 3'd5);
        wait_drained();
    endtask

    task automatic test_idling();
        send_idle_pct = 0;  recv_stall_pct = 0;  send_random(200, 1);
        send_idle_pct = 81; recv_stall_pct = 0;  send_random(150, 1);
        send_idle_pct = 0;  recv_stall_pct = 81; send_random(150, 0);
        send_idle_pct = 23; recv_stall_pct = 23; send_random(200, 1);
        send_idle_pct = 0;  recv_stall_pct = 0;  send_random(150, 0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 400;
        send_random(100, 1);
        wait_drained();
    endtask

    // receiver side with random stalls and a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            result.ready <= 1'b0;
        end
        else
        begin
            result.ready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        smx_result_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result", result.best_class, '0);
            end
            else
            begin
                want = expected_q.pop_front();
                if (result.best_class !== want.best_class)
                    report_mismatch("best_class", result.best_class, want.best_class);
                if (result.confidence !== want.confidence)
                    report_mismatch("confidence", result.confidence, want.confidence);
                if (result.class_hits !== want.class_hits)
                    report_mismatch("class_hits", result.class_hits, want.class_hits);
                if (result.class_conf_total !== want.class_conf_total)
                    report_mismatch("class_conf_total", result.class_conf_total,
                                    want.class_conf_total);
                if (result.total_hits !== want.total_hits)
                    report_mismatch("total_hits", result.total_hits, want.total_hits);
                if (result.leading_class !== want.leading_class)
                    report_mismatch("leading_class", result.leading_class,
                                    want.leading_class);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((sample.valid && sample.ready) || (result.valid && result.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        errors = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        tally_total = '0;
        for (int i = 0; i < NCLS; i++)
        begin
            tally_hits[i] = '0;
            tally_conf[i] = '0;
        end
        sample.valid = 1'b0;
        sample.logit_a = '0;
        sample.logit_b = '0;
        sample.logit_c = '0;
        sample.logit_d = '0;
        sample.logit_e = '0;
        sample.num_valid = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_idling();
        test_backpressure();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
